@@ src/l2u_pkg.sv @@
// shared types and constants for the text to ucs-2 decoder
package l2u_pkg;

  // storage depths and address widths
  localparam int MAP_DEPTH   = 65536;
  localparam int GLYPH_DEPTH = 65536;
  localparam int FLAG_DEPTH  = 256;
  localparam int MAP_AW      = $clog2(MAP_DEPTH);
  localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);
  localparam int FLAG_AW     = $clog2(FLAG_DEPTH);

  // item opcodes
  localparam logic [1:0] OP_CONVERT = 2'd0;
  localparam logic [1:0] OP_FLAG    = 2'd1;
  localparam logic [1:0] OP_MAP     = 2'd2;
  localparam logic [1:0] OP_GLYPH   = 2'd3;

  // configuration register indexes
  localparam int         CFG_IDX_W     = 1;
  localparam logic [0:0] CFG_UTF8_MODE = 1'd0;
  localparam logic [0:0] CFG_MAP_SIZE  = 1'd1;

  // kind of result held in the output stage
  localparam logic [1:0] KIND_EOS   = 2'd0;
  localparam logic [1:0] KIND_MAP   = 2'd1;
  localparam logic [1:0] KIND_GLYPH = 2'd2;

  localparam logic [15:0] QMARK = 16'd63;

  // utf-8 lead byte masks
  localparam logic [7:0] LEAD2_MASK = 8'he0;
  localparam logic [7:0] LEAD2_VAL  = 8'hc0;
  localparam logic [7:0] LEAD3_MASK = 8'hf0;
  localparam logic [7:0] LEAD3_VAL  = 8'he0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic [15:0] table_index;
    logic [15:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
  } out_item_t;

endpackage

@@ src/local_or_utf8_text_to_ucs2_unit.sv @@
// byte stream to 16-bit code unit decoder, code-page and utf-8 modes
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  in      | input     | in_valid / in_stall   | in_item (opcode, byte, index, value)
//  out     | output    | out_valid / out_stall | out_item (code_unit, end_of_string)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle while no result waits on a stalled output stage; a byte
// is held in stage a, its result in stage c; the flag table is read at acceptance,
// the map and glyph memories one stage later. after reset the glyph memory is swept
// clear, one entry a cycle, no item taken meanwhile; cfg writes are always taken
// a stalled result holds in the output stage; items that give no result
// (table writes, partial sequences) keep flowing past it
module local_or_utf8_text_to_ucs2_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  l2u_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output l2u_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [l2u_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  // configuration
  logic        utf8_mode_r;
  logic [15:0] map_size_r;
  logic        cfg_wr;

  // sequence state
  logic [1:0]  pend_r, pend_nxt;
  logic        skip_r, skip_nxt;
  logic [15:0] part_r, part_nxt;

  // glyph clearing sweep
  logic                         clearing_r;
  logic [l2u_pkg::GLYPH_AW-1:0] clr_idx_r;

  // storage
  logic                flag_mem_r  [l2u_pkg::FLAG_DEPTH];
  logic [15:0]         map_mem_r   [l2u_pkg::MAP_DEPTH];
  logic                glyph_mem_r [l2u_pkg::GLYPH_DEPTH];

  // stage a: registered item plus its flag read
  logic              a_valid_r;
  l2u_pkg::in_item_t a_item_r;
  logic              a_flag_r;
  logic              a_go;
  logic              a_res;
  logic [1:0]        a_kind;
  logic [15:0]       a_code;
  logic [15:0]       cont_sum;
  logic              map_oob;
  logic              glyph_oob;
  logic              accept;

  // stage c: output stage with memory read data
  logic        c_valid_r;
  logic [1:0]  c_kind_r;
  logic [15:0] c_code_r;
  logic        c_oob_r;
  logic [15:0] c_map_r;
  logic        c_glyph_r;
  logic        c_ready;
  logic        c_load;

  logic        map_wr;
  logic        glyph_wr;
  logic        glyph_wdata;
  logic [l2u_pkg::GLYPH_AW-1:0] glyph_waddr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // result stage can take a new result when empty or draining
  assign c_ready  = !c_valid_r || !out_stall;
  assign a_go     = a_valid_r && (!a_res || c_ready);
  assign c_load   = a_go && a_res;
  assign in_stall = clearing_r || (a_valid_r && !a_go);
  assign accept   = in_valid && !in_stall;

  // per-byte decode on the held item
  always_comb begin
    a_res    = 1'b0;
    a_kind   = l2u_pkg::KIND_EOS;
    a_code   = 16'd0;
    pend_nxt = pend_r;
    skip_nxt = skip_r;
    part_nxt = part_r;
    // continuation adds six bits, shifted up when two bytes remain
    cont_sum = pend_r[0] ? (part_r + {10'd0, a_item_r.data_byte[5:0]})
                         : (part_r + {4'd0, a_item_r.data_byte[5:0], 6'd0});
    if (a_item_r.opcode == l2u_pkg::OP_CONVERT) begin
      if (a_item_r.data_byte == 8'd0) begin
        // terminator drops any open sequence
        a_res    = 1'b1;
        a_kind   = l2u_pkg::KIND_EOS;
        pend_nxt = 2'd0;
        skip_nxt = 1'b0;
        part_nxt = 16'd0;
      end else if (utf8_mode_r) begin
        if (skip_r) begin
          if (pend_r != 2'd0) begin
            pend_nxt = pend_r - 2'd1;
          end
          if (pend_nxt == 2'd0) begin
            skip_nxt = 1'b0;
          end
        end else if (pend_r != 2'd0) begin
          pend_nxt = pend_r - 2'd1;
          if (pend_r == 2'd1) begin
            a_res    = 1'b1;
            a_kind   = l2u_pkg::KIND_GLYPH;
            a_code   = cont_sum;
            part_nxt = 16'd0;
          end else begin
            part_nxt = cont_sum;
          end
        end else if (!a_item_r.data_byte[7]) begin
          a_res  = 1'b1;
          a_kind = l2u_pkg::KIND_GLYPH;
          a_code = {8'd0, a_item_r.data_byte};
        end else if ((a_item_r.data_byte & l2u_pkg::LEAD2_MASK) == l2u_pkg::LEAD2_VAL) begin
          part_nxt = {5'd0, a_item_r.data_byte[4:0], 6'd0};
          pend_nxt = 2'd1;
        end else if ((a_item_r.data_byte & l2u_pkg::LEAD3_MASK) == l2u_pkg::LEAD3_VAL) begin
          part_nxt = {a_item_r.data_byte[3:0], 12'd0};
          pend_nxt = 2'd2;
        end else begin
          // bad lead: question mark now, skip the next three bytes
          part_nxt = 16'd0;
          pend_nxt = 2'd3;
          skip_nxt = 1'b1;
          a_res    = 1'b1;
          a_kind   = l2u_pkg::KIND_GLYPH;
          a_code   = l2u_pkg::QMARK;
        end
      end else begin
        if (pend_r != 2'd0) begin
          // trail byte completes a double-byte code
          a_res    = 1'b1;
          a_kind   = l2u_pkg::KIND_MAP;
          a_code   = {part_r[7:0], a_item_r.data_byte};
          pend_nxt = 2'd0;
          skip_nxt = 1'b0;
          part_nxt = 16'd0;
        end else if (a_flag_r) begin
          a_res  = 1'b1;
          a_kind = l2u_pkg::KIND_MAP;
          a_code = {8'd0, a_item_r.data_byte};
        end else begin
          part_nxt = {8'd0, a_item_r.data_byte};
          pend_nxt = 2'd1;
        end
      end
    end
  end

  assign map_oob   = ({1'b0, a_code} >= {1'b0, map_size_r}) ||
                     ({1'b0, a_code} >= 17'(l2u_pkg::MAP_DEPTH));
  assign glyph_oob = {1'b0, a_code} >= 17'(l2u_pkg::GLYPH_DEPTH);

  // configuration and sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf8_mode_r <= 1'b0;
      map_size_r  <= 16'd0;
      pend_r      <= 2'd0;
      skip_r      <= 1'b0;
      part_r      <= 16'd0;
    end else if (cfg_wr && cfg_index == l2u_pkg::CFG_UTF8_MODE) begin
      // mode change drops the open sequence
      utf8_mode_r <= cfg_data[0];
      pend_r      <= 2'd0;
      skip_r      <= 1'b0;
      part_r      <= 16'd0;
    end else begin
      if (cfg_wr && cfg_index == l2u_pkg::CFG_MAP_SIZE) begin
        map_size_r <= cfg_data;
      end
      if (a_go) begin
        pend_r <= pend_nxt;
        skip_r <= skip_nxt;
        part_r <= part_nxt;
      end
    end
  end

  // glyph clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + l2u_pkg::GLYPH_AW'(1);
      if (clr_idx_r == l2u_pkg::GLYPH_AW'(l2u_pkg::GLYPH_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // stage a control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (accept) begin
      a_valid_r <= 1'b1;
    end else if (a_go) begin
      a_valid_r <= 1'b0;
    end
  end

  // item register and single-byte flag table, both at acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      a_item_r <= in_item;
      a_flag_r <= flag_mem_r[in_item.data_byte];
      if (in_item.opcode == l2u_pkg::OP_FLAG) begin
        flag_mem_r[in_item.table_index[l2u_pkg::FLAG_AW-1:0]] <= in_item.table_value[0];
      end
    end
  end

  // code map memory
  assign map_wr = a_go && (a_item_r.opcode == l2u_pkg::OP_MAP) &&
                  ({1'b0, a_item_r.table_index} < 17'(l2u_pkg::MAP_DEPTH));

  always_ff @(posedge clk) begin
    if (map_wr) begin
      map_mem_r[a_item_r.table_index[l2u_pkg::MAP_AW-1:0]] <= a_item_r.table_value;
    end
    if (c_load) begin
      c_map_r <= map_mem_r[a_code[l2u_pkg::MAP_AW-1:0]];
    end
  end

  // glyph memory, one write port shared with the sweep
  assign glyph_wr    = clearing_r ||
                       (a_go && (a_item_r.opcode == l2u_pkg::OP_GLYPH) &&
                        ({1'b0, a_item_r.table_index} < 17'(l2u_pkg::GLYPH_DEPTH)));
  assign glyph_waddr = clearing_r ? clr_idx_r : a_item_r.table_index[l2u_pkg::GLYPH_AW-1:0];
  assign glyph_wdata = clearing_r ? 1'b0 : a_item_r.table_value[0];

  always_ff @(posedge clk) begin
    if (glyph_wr) begin
      glyph_mem_r[glyph_waddr] <= glyph_wdata;
    end
    if (c_load) begin
      c_glyph_r <= glyph_mem_r[a_code[l2u_pkg::GLYPH_AW-1:0]];
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_load) begin
      c_valid_r <= 1'b1;
    end else if (!out_stall) begin
      c_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      c_kind_r <= a_kind;
      c_code_r <= a_code;
      c_oob_r  <= (a_kind == l2u_pkg::KIND_MAP) ? map_oob : glyph_oob;
    end
  end

  assign out_valid = c_valid_r;

  always_comb begin
    case (c_kind_r)
      l2u_pkg::KIND_EOS: begin
        out_item.code_unit     = 16'd0;
        out_item.end_of_string = 1'b1;
      end
      l2u_pkg::KIND_MAP: begin
        out_item.code_unit     = (c_oob_r || c_map_r == 16'd0) ? l2u_pkg::QMARK : c_map_r;
        out_item.end_of_string = 1'b0;
      end
      l2u_pkg::KIND_GLYPH: begin
        out_item.code_unit     = (c_oob_r || !c_glyph_r) ? l2u_pkg::QMARK : c_code_r;
        out_item.end_of_string = 1'b0;
      end
      default: begin
        out_item.code_unit     = l2u_pkg::QMARK;
        out_item.end_of_string = 1'b0;
      end
    endcase
  end

  // no item may be in flight while the glyph sweep runs
  a_sweep_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !a_valid_r && !c_valid_r)
    else $error("item in flight during glyph sweep");

  // code-page decoding never opens more than one trail byte
  a_cp_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !utf8_mode_r |-> pend_r <= 2'd1)
    else $error("code-page sequence longer than two bytes");

  // skipping only arises from a bad utf-8 lead
  a_skip_mode: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> utf8_mode_r && pend_r != 2'd0)
    else $error("skip state outside utf-8 sequence");

  // a terminator leaves no open sequence behind
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && a_item_r.opcode == l2u_pkg::OP_CONVERT && a_item_r.data_byte == 8'd0 &&
     !cfg_wr) |=> pend_r == 2'd0 && !skip_r && part_r == 16'd0)
    else $error("sequence state left open after terminator");

  // a held result is not overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r && out_stall) |-> !c_load)
    else $error("result overwritten while stalled");

endmodule

@@ bench/l2u_decode_checker.sv @@
// checker for the text decoder: predicts every code unit and compares each result
module l2u_decode_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  l2u_pkg::in_item_t             in_item,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  l2u_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [l2u_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output int                            mismatches,
  output int                            awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  import l2u_pkg::*;

  // predictor copy of registers and sequence state
  bit          utf8_on;
  logic [15:0] map_limit;
  logic [1:0]  seq_left;
  bit          skipping;
  logic [15:0] seq_code;
  bit          single_flag [FLAG_DEPTH];
  logic [15:0] cp_map      [MAP_DEPTH];
  bit          glyph_on    [GLYPH_DEPTH];
  out_item_t   units_due   [$];
  int          bad;

  function automatic logic [15:0] glyph_gate(input logic [15:0] unit);
    if (unit >= GLYPH_DEPTH || !glyph_on[unit]) return QMARK;
    return unit;
  endfunction

  function automatic logic [15:0] map_read(input logic [15:0] code);
    if (code >= map_limit || code >= MAP_DEPTH || cp_map[code] == 16'h0000) return QMARK;
    return cp_map[code];
  endfunction

  task automatic clear_seq();
    seq_left = 2'd0;
    skipping = 1'b0;
    seq_code = 16'h0000;
  endtask

  task automatic push_unit(input logic [15:0] unit, input logic eos);
    out_item_t r;
    r.code_unit     = unit;
    r.end_of_string = eos;
    units_due.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    out_item_t   want;
    logic [7:0]  b;
    logic [15:0] code;
    if (!rst_n) begin
      utf8_on   = 1'b0;
      map_limit = 16'h0000;
      clear_seq();
      units_due.delete();
      bad = 0;
      for (int g = 0; g < GLYPH_DEPTH; g++) glyph_on[g] = 1'b0;
    end else begin
      // results first: a result never stems from an item taken at the same edge
      if (out_valid && !out_stall) begin
        if (units_due.size() == 0) begin
          bad++;
          $error("unexpected result: code_unit %h end_of_string %b",
                 out_item.code_unit, out_item.end_of_string);
        end else begin
          want = units_due.pop_front();
          if (out_item.code_unit !== want.code_unit) begin
            bad++;
            $error("code_unit: expected %h, actual %h", want.code_unit, out_item.code_unit);
          end
          if (out_item.end_of_string !== want.end_of_string) begin
            bad++;
            $error("end_of_string: expected %b, actual %b",
                   want.end_of_string, out_item.end_of_string);
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_UTF8_MODE) begin
          utf8_on = cfg_data[0];
          clear_seq();
        end else if (cfg_index == CFG_MAP_SIZE) begin
          map_limit = cfg_data;
        end
      end

      if (in_valid && !in_stall) begin
        b = in_item.data_byte;
        case (in_item.opcode)
          OP_FLAG: single_flag[in_item.table_index[FLAG_AW-1:0]] = in_item.table_value[0];
          OP_MAP: begin
            if (in_item.table_index < MAP_DEPTH)
              cp_map[in_item.table_index] = in_item.table_value;
          end
          OP_GLYPH: begin
            if (in_item.table_index < GLYPH_DEPTH)
              glyph_on[in_item.table_index] = in_item.table_value[0];
          end
          OP_CONVERT: begin
            if (b == 8'h00) begin
              clear_seq();
              push_unit(16'h0000, 1'b1);
            end else if (utf8_on) begin
              if (skipping) begin
                if (seq_left != 2'd0) seq_left = seq_left - 2'd1;
                if (seq_left == 2'd0) skipping = 1'b0;
              end else if (seq_left != 2'd0) begin
                // continuation bits are taken as they come
                if (seq_left == 2'd2) seq_code = seq_code + {4'h0, b[5:0], 6'h00};
                else seq_code = seq_code + {10'h000, b[5:0]};
                seq_left = seq_left - 2'd1;
                if (seq_left == 2'd0) begin
                  push_unit(glyph_gate(seq_code), 1'b0);
                  seq_code = 16'h0000;
                end
              end else if (b < 8'h80) begin
                push_unit(glyph_gate({8'h00, b}), 1'b0);
              end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
                seq_code = {5'h00, b[4:0], 6'h00};
                seq_left = 2'd1;
              end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
                seq_code = {b[3:0], 12'h000};
                seq_left = 2'd2;
              end else begin
                seq_code = 16'h0000;
                seq_left = 2'd3;
                skipping = 1'b1;
                push_unit(glyph_gate(QMARK), 1'b0);
              end
            end else begin
              if (seq_left != 2'd0) begin
                code = {seq_code[7:0], b};
                clear_seq();
                push_unit(map_read(code), 1'b0);
              end else if (single_flag[b]) begin
                push_unit(map_read({8'h00, b}), 1'b0);
              end else begin
                seq_code = {8'h00, b};
                seq_left = 2'd1;
              end
            end
          end
          default: ;
        endcase
      end
    end
    awaiting   <= units_due.size();
    mismatches <= bad;
  end

endmodule

@@ bench/tb_local_or_utf8_text_to_ucs2_unit.sv @@
// testbench top: drives table loads, text bytes and register writes, gives the verdict
module tb_local_or_utf8_text_to_ucs2_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import l2u_pkg::*;

  // a run this long means something is stuck
  localparam int RUN_LIMIT       = 1000000;
  // wait after the last expected result, so that the pipeline is empty
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASES          = 10;
  localparam int STEPS_PER_PHASE = 95;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;
  int                   mismatches;
  int                   awaiting;

  local_or_utf8_text_to_ucs2_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  l2u_decode_checker decode_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run guard
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus-side view of what the block will read, so that no byte ever
  // looks up a flag or map entry that was never loaded
  bit          single_byte [FLAG_DEPTH];
  bit          map_loaded  [MAP_DEPTH];
  bit          utf8_now;
  logic [15:0] size_now;
  bit          lead_open;
  logic [7:0]  lead_hold;
  logic [15:0] glyph_codes [$];
  int          burst_left;

  // one item on the input channel; bursts of random length, random gaps between
  task automatic offer(input in_item_t it);
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long unbroken burst
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // table load: flag, map entry or glyph bit
  task automatic put_table(input logic [1:0] op, input logic [15:0] idx,
                           input logic [15:0] val);
    in_item_t it;
    it.opcode      = op;
    it.data_byte   = 8'($urandom);
    it.table_index = idx;
    it.table_value = val;
    if (op == OP_FLAG) single_byte[idx[FLAG_AW-1:0]] = val[0];
    else if (op == OP_MAP) map_loaded[idx] = 1'b1;
    else if (op == OP_GLYPH && val[0] && glyph_codes.size() < 512) glyph_codes.push_back(idx);
    offer(it);
  endtask

  // one text byte; in code-page mode a map entry is loaded first if the byte
  // would otherwise look up an entry never written
  task automatic put_byte(input logic [7:0] b);
    in_item_t    it;
    logic [15:0] code;
    bit          reads;
    reads = 1'b0;
    code  = 16'h0000;
    if (!utf8_now && b != 8'h00) begin
      if (lead_open) begin
        code  = {lead_hold, b};
        reads = 1'b1;
      end else if (single_byte[b]) begin
        code  = {8'h00, b};
        reads = 1'b1;
      end
    end
    // an occasional zero entry turns into '?'
    if (reads && code < size_now && !map_loaded[code])
      put_table(OP_MAP, code, ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom));
    if (!utf8_now) begin
      if (b == 8'h00 || lead_open) begin
        lead_open = 1'b0;
      end else if (!single_byte[b]) begin
        lead_open = 1'b1;
        lead_hold = b;
      end
    end
    it.opcode      = OP_CONVERT;
    it.data_byte   = b;
    it.table_index = 16'($urandom);
    it.table_value = 16'($urandom);
    offer(it);
  endtask

  // stop offering, let every expected result arrive, then let the pipeline empty
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers back to back, valid held high across the pair
  task automatic program_regs(input bit mode, input logic [15:0] size);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_UTF8_MODE;
    cfg_data  <= {15'($urandom), mode};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_MAP_SIZE;
    cfg_data  <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    utf8_now  = mode;
    size_now  = size;
    // a mode write drops any open sequence
    lead_open = 1'b0;
  endtask

  initial begin : stimulus
    int          pick;
    int          kind;
    int          nbytes;
    bit          mode;
    logic [15:0] size;
    logic [15:0] unit;
    logic [15:0] idx;
    logic [15:0] val;
    logic [1:0]  tag_a;
    logic [1:0]  tag_b;
    bit          flag;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_UTF8_MODE;
    cfg_data  <= 16'h0000;
    utf8_now   = 1'b0;
    size_now   = 16'h0000;
    lead_open  = 1'b0;
    lead_hold  = 8'h00;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed utf-8: glyph absent, 1/2/3-byte extremes, bad lead and skip,
    // zero inside a sequence, table write inside a sequence, unchecked continuation
    program_regs(1'b1, 16'h0000);
    put_byte(8'h41);
    put_table(OP_GLYPH, 16'h0041, 16'h0001);
    put_table(OP_GLYPH, 16'h007f, 16'h0001);
    put_table(OP_GLYPH, 16'h07ff, 16'h0001);
    put_table(OP_GLYPH, 16'hffff, 16'h0001);
    put_byte(8'h41);
    put_byte(8'h7f);
    put_byte(8'hdf);
    put_byte(8'hbf);
    put_byte(8'hef);
    put_byte(8'hbf);
    put_byte(8'hbf);
    put_byte(8'hff);
    put_byte(8'h41);
    put_byte(8'h42);
    put_byte(8'h43);
    put_byte(8'h41);
    put_table(OP_GLYPH, QMARK, 16'h0001);
    put_byte(8'h80);
    put_byte(8'h00);
    put_byte(8'hc3);
    put_byte(8'h00);
    put_byte(8'he1);
    put_table(OP_GLYPH, 16'h1000, 16'h0001);
    put_byte(8'h80);
    put_byte(8'h80);
    put_byte(8'hc1);
    put_byte(8'hff);
    drain();

    // code-page: whole flag table first, a few bytes forced to known roles
    program_regs(1'b0, 16'hffff);
    for (int i = 0; i < FLAG_DEPTH; i++) begin
      if (i == 8'h81 || i == 8'hff) flag = 1'b0;
      else if (i == 8'h41 || i == 8'h01) flag = 1'b1;
      else flag = ($urandom_range(0, 2) != 0);
      put_table(OP_FLAG, {8'($urandom), 8'(i)}, {15'($urandom), flag});
    end
    put_byte(8'h41);
    put_byte(8'h81);
    put_byte(8'h40);
    // top code sits at map_size, so it is out of range
    put_byte(8'hff);
    put_byte(8'hff);
    put_byte(8'h81);
    put_table(OP_GLYPH, 16'h0041, 16'h0001);
    put_byte(8'hfe);
    put_byte(8'h81);
    put_byte(8'h00);
    put_table(OP_MAP, 16'h0041, 16'h0000);
    put_byte(8'h41);
    put_byte(8'h01);
    put_byte(8'h00);
    drain();

    // random phases, register extremes first
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin mode = 1'b0; size = 16'h0000; end
        1: begin mode = 1'b1; size = 16'hffff; end
        2: begin mode = 1'b0; size = 16'hffff; end
        3: begin mode = 1'b1; size = 16'h0000; end
        4: begin mode = 1'b0; size = 16'h0001; end
        default: begin
          mode = $urandom_range(0, 1);
          size = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 1024)) : 16'($urandom);
        end
      endcase
      program_regs(mode, size);
      for (int s = 0; s < STEPS_PER_PHASE; s++) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          case ($urandom_range(0, 2))
            0: put_table(OP_FLAG, 16'($urandom), 16'($urandom));
            1: put_table(OP_MAP, 16'($urandom),
                         ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom));
            default: begin
              // glyphs mostly where utf-8 characters will land
              case ($urandom_range(0, 2))
                0:       idx = 16'($urandom_range(1, 127));
                1:       idx = 16'($urandom_range(128, 2047));
                default: idx = 16'($urandom);
              endcase
              val    = 16'($urandom);
              val[0] = ($urandom_range(0, 9) < 7);
              put_table(OP_GLYPH, idx, val);
            end
          endcase
        end else if (!utf8_now) begin
          put_byte(($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
        end else begin
          kind = $urandom_range(0, 99);
          if (kind < 60) begin
            // well-formed character, often one that has a glyph
            if (glyph_codes.size() != 0 && $urandom_range(0, 1) != 0) begin
              unit = glyph_codes[$urandom_range(0, glyph_codes.size() - 1)];
            end else begin
              case ($urandom_range(0, 2))
                0:       unit = 16'($urandom_range(0, 127));
                1:       unit = 16'($urandom_range(128, 2047));
                default: unit = 16'($urandom);
              endcase
            end
            nbytes = (unit < 16'h0080) ? 1 : (unit < 16'h0800) ? 2 : 3;
            // zero and the odd character go out in overlong form
            if (unit == 16'h0000 || ($urandom_range(0, 9) == 0 && nbytes < 3)) nbytes++;
            // continuation tags are not checked by the block
            tag_a = ($urandom_range(0, 4) == 0) ? 2'($urandom) : 2'b10;
            tag_b = ($urandom_range(0, 4) == 0) ? 2'($urandom) : 2'b10;
            case (nbytes)
              1: put_byte(unit[7:0]);
              2: begin
                put_byte({3'b110, unit[10:6]});
                put_byte({tag_a, unit[5:0]});
              end
              default: begin
                put_byte({4'b1110, unit[15:12]});
                put_byte({tag_a, unit[11:6]});
                put_byte({tag_b, unit[5:0]});
              end
            endcase
          end else if (kind < 75) begin
            // bad lead then up to four random bytes, mostly inside its skip window
            put_byte(($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h80, 8'hbf))
                                                  : 8'($urandom_range(8'hf0, 8'hff)));
            repeat ($urandom_range(0, 4)) put_byte(8'($urandom));
          end else if (kind < 85) begin
            put_byte(8'h00);
          end else begin
            put_byte(8'($urandom));
          end
        end
      end
      drain();
    end

    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // receiver: stall pattern of its own, changing every stretch, with a long
  // hold-off now and then so that the block fills and stalls its input
  initial begin : receiver
    int style;
    int span;
    int seg;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    seg = 0;
    forever begin
      if (seg % 40 == 6) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(20, 200);
        for (int k = 0; k < span; k++) begin
          case (style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= k[0];
          endcase
          @(posedge clk);
        end
      end
      seg++;
    end
  end

endmodule
